// ----- design/sba_pkg.sv -----
// sba_pkg: types, constants and helper functions for the slab bitmap allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sba_pkg;

    localparam int SLAB_COUNT_DEF = 16;
    localparam int PAGE_BYTES     = 4096;
    localparam int HEADER_BYTES   = 32;
    localparam int SIZE_W         = 12;
    localparam int SLAB_W         = 4;
    localparam int OFF_W          = 15;
    localparam int IDX_W          = 8;
    localparam int STAMP_W        = 32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLAB = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        CL_UNUSED  = 2'd0,
        CL_FREE    = 2'd1,
        CL_PARTIAL = 2'd2,
        CL_FULL    = 2'd3
    } t_class;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PER,
        S_SCAN_P,
        S_SCAN_F,
        S_PICK,
        S_BITS,
        S_ALLOC_END,
        S_DIV,
        S_FREE_CHK,
        S_FREE_END,
        S_MUL,
        S_DONE
    } t_state;

    // control from sequencer to the shared divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic       busy;
        logic       done;
    } t_div_sts;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
        eff_size = (sz < SIZE_W'(16)) ? SIZE_W'(16) : sz;
    endfunction

endpackage

// ----- design/sba_divider.sv -----
// sba_divider: restoring divider, one quotient bit per cycle.
// Depends on sba_pkg.
`timescale 1ns / 1ps
module sba_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sba_pkg::t_div_ctl             i_ctl,
    input  logic [sba_pkg::OFF_W-1:0]     i_num,
    input  logic [sba_pkg::SIZE_W-1:0]    i_den,
    output sba_pkg::t_div_sts             o_sts,
    output logic [sba_pkg::OFF_W-1:0]     o_quot
);
    import sba_pkg::*;

    logic [OFF_W-1:0]  r_q, n_q;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SIZE_W:0]   trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_q[OFF_W-1]};
        if (i_ctl.start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 4'(OFF_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_den}) begin
                n_rem = SIZE_W'(trial - {1'b0, i_den});
                n_q   = {r_q[OFF_W-2:0], 1'b1};
            end else begin
                n_rem = trial[SIZE_W-1:0];
                n_q   = {r_q[OFF_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;
endmodule

// ----- design/slab_bitmap_allocator.sv -----
// slab_bitmap_allocator: top level, sequencer, slab tables and bitmap memory.
// Depends on sba_pkg and sba_divider.
//
//  channel  | ports                                          | handshake
//  config   | i_cfg_we, i_cfg_data                           | write when i_cfg_we
//  command  | i_start, i_operation, i_slab_number, i_byte_offset | start && !busy
//  result   | o_done, o_status, o_result_slab, o_object_index, o_object_offset | one cycle
//
// Every command first runs the shared divider for the slot count.
// Allocate: scan of the slab stamps, one slab a cycle (all slabs for a partial one,
// then all again for a free one when no slab is partial), pick, bitmap search word
// by word, end, multiply, done.
// Free: slot count, offset division, word read, end, multiply, done.
// The next word is taken in the strobe cycle at the earliest.
// Reset is synchronous; the result strobe lasts one cycle and cannot stall.
`timescale 1ns / 1ps
module slab_bitmap_allocator #(
    parameter int SLAB_COUNT = sba_pkg::SLAB_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sba_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                          i_start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [sba_pkg::SLAB_W-1:0]    i_slab_number,
    input  logic [sba_pkg::OFF_W-1:0]     i_byte_offset,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [sba_pkg::SLAB_W-1:0]    o_result_slab,
    output logic [sba_pkg::IDX_W-1:0]     o_object_index,
    output logic [sba_pkg::OFF_W-1:0]     o_object_offset
);
    import sba_pkg::*;

    localparam int SW = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
    localparam int CW = $clog2(SLAB_COUNT + 1);
    localparam int WORDS = SLAB_COUNT * 4;
    localparam int AW = $clog2(WORDS);

    // bitmap memory, one 64-bit word per entry; per-slab clear is handled by
    // word valid bits
    logic [63:0]          mem [WORDS];
    logic [WORDS-1:0]     r_wvalid;
    logic [63:0]          r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [63:0]          mem_wdata;
    logic                 r_rvalid_q;

    t_class               r_cls   [SLAB_COUNT];
    logic [7:0]           r_used  [SLAB_COUNT];
    logic [STAMP_W-1:0]   r_stamp [SLAB_COUNT];
    logic [STAMP_W-1:0]   r_ctr;
    logic [SIZE_W-1:0]    r_size;

    t_state               r_st, n_st;
    logic [CW-1:0]        r_i;
    logic                 r_found;
    logic [SW-1:0]        r_best;
    logic [STAMP_W-1:0]   r_bstamp;
    logic                 r_op;
    logic [SLAB_W-1:0]    r_inslab;
    logic [OFF_W-1:0]     r_inoff;
    logic [SW-1:0]        r_sel;
    logic [1:0]           r_word;
    logic [8:0]           r_idx;
    logic [8:0]           r_per;
    logic [1:0]           r_status;
    logic                 r_done;
    logic [OFF_W-1:0]     r_prod;
    logic [3:0]           r_mcnt;

    t_div_ctl             div_ctl;
    t_div_sts             div_sts;
    logic [OFF_W-1:0]     div_q;
    logic [OFF_W-1:0]     div_num;
    logic [SIZE_W-1:0]    esz;

    assign esz = eff_size(r_size);

    // slab pages from the object size; budget/size in the divider gives the
    // slot count, then the same divider turns a free offset into a slot
    logic [3:0]  pages;
    assign pages = (esz < SIZE_W'(64)) ? 4'd1 : 4'(1 + ((32'(esz) * 8 - 1) >> 12));
    logic [15:0] budget;
    assign budget = {pages, 12'd0} - 16'(HEADER_BYTES);

    assign div_num = (r_st == S_IDLE) ? budget[OFF_W-1:0]
                                      : r_inoff - OFF_W'(HEADER_BYTES);

    sba_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (div_ctl),
        .i_num  (div_num),
        .i_den  (esz),
        .o_sts  (div_sts),
        .o_quot (div_q)
    );

    // scan helpers
    logic [SW-1:0] cur;
    assign cur = r_i[SW-1:0];
    logic [63:0] word_eff;
    assign word_eff = r_wvalid[{r_sel, r_word}] ? r_rdata : 64'd0;

    logic [6:0] ffz;
    always_comb begin
        ffz = 7'd64;
        for (int b = 63; b >= 0; b--)
            if (!word_eff[b]) ffz = 7'(b);
    end

    logic [8:0] cand;
    assign cand = {1'b0, r_word, 6'd0} + {2'd0, ffz};

    logic [7:0] fidx;
    assign fidx = div_q[7:0];
    logic       fbig;
    assign fbig = (div_q >= OFF_W'(r_per));

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:      if (i_start) n_st = S_PER;
            S_PER:       if (div_sts.done) n_st = (r_op == OP_FREE) ? S_DIV : S_SCAN_P;
            // a partial slab wins outright; free slabs are scanned only without one
            S_SCAN_P:    if (r_i == CW'(SLAB_COUNT - 1))
                             n_st = (r_found || r_cls[cur] == CL_PARTIAL) ? S_PICK : S_SCAN_F;
            S_SCAN_F:    if (r_i == CW'(SLAB_COUNT - 1)) n_st = S_PICK;
            S_PICK:      n_st = S_BITS;
            S_BITS:      if (r_rvalid_q && (ffz != 7'd64 || r_word == 2'd3 ||
                             cand >= r_per)) n_st = S_ALLOC_END;
            S_ALLOC_END: n_st = S_MUL;
            S_DIV:       if (div_sts.done) n_st = S_FREE_CHK;
            S_FREE_CHK:  if (r_rvalid_q) n_st = S_FREE_END;
            S_FREE_END:  n_st = S_MUL;
            S_MUL:       if (r_mcnt == '0) n_st = S_DONE;
            S_DONE:      n_st = S_IDLE;
            default:     n_st = S_IDLE;
        endcase
    end

    always_comb begin
        div_ctl.start = ((r_st == S_IDLE) && i_start) ||
                        ((r_st == S_PER) && div_sts.done && (r_op == OP_FREE));
        busy = (r_st != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_done  <= 1'b0;
            r_ctr   <= '0;
            r_size  <= SIZE_W'(16);
            r_wvalid <= '0;
            for (int s = 0; s < SLAB_COUNT; s++) begin
                r_cls[s]   <= CL_UNUSED;
                r_used[s]  <= '0;
                r_stamp[s] <= '0;
            end
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == S_DONE);
            if (i_cfg_we) r_size <= i_cfg_data;
            if (mem_we) r_wvalid[mem_addr] <= 1'b1;
            case (r_st)
                S_IDLE: begin
                    r_op     <= i_operation;
                    r_inslab <= i_slab_number;
                    r_inoff  <= i_byte_offset;
                    r_i      <= '0;
                    r_found  <= 1'b0;
                    r_status <= ST_OK;
                    r_idx    <= '0;
                    r_word   <= '0;
                    r_rvalid_q <= 1'b0;
                end
                S_SCAN_P, S_SCAN_F: begin
                    if (r_cls[cur] == ((r_st == S_SCAN_P) ? CL_PARTIAL : CL_FREE)
                        && (!r_found || r_stamp[cur] > r_bstamp)) begin
                        r_found  <= 1'b1;
                        r_best   <= cur;
                        r_bstamp <= r_stamp[cur];
                    end
                    if (r_st == S_SCAN_P && r_i == CW'(SLAB_COUNT - 1)) r_i <= '0;
                    else r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
            // slot count, capped at the bitmap size
            if (r_st == S_PER && div_sts.done)
                r_per <= (div_q > OFF_W'(256)) ? 9'd256 : div_q[8:0];
            if (r_st == S_PICK) begin
                r_word <= '0;
                r_rvalid_q <= 1'b0;
                if (r_found) begin
                    r_sel <= r_best;
                    if (r_cls[r_best] == CL_FREE) begin
                        r_cls[r_best]   <= CL_PARTIAL;
                        r_ctr           <= r_ctr + 1'b1;
                        r_stamp[r_best] <= r_ctr + 1'b1;
                    end
                end else begin : pick_unused
                    logic hit;
                    logic [SW-1:0] u;
                    hit = 1'b0;
                    u = '0;
                    for (int s = SLAB_COUNT - 1; s >= 0; s--)
                        if (r_cls[s] == CL_UNUSED) begin
                            hit = 1'b1;
                            u = SW'(s);
                        end
                    if (hit) begin
                        r_sel <= u;
                        r_used[u]  <= '0;
                        r_cls[u]   <= CL_PARTIAL;
                        r_ctr      <= r_ctr + 2'd2;
                        r_stamp[u] <= r_ctr + 2'd2;
                        for (int w = 0; w < 4; w++)
                            r_wvalid[{u, 2'(w)}] <= 1'b0;
                    end else begin
                        r_status <= ST_NO_SLAB;
                        r_sel    <= '0;
                    end
                end
            end
            if (r_st == S_BITS) begin
                r_rvalid_q <= ~r_rvalid_q;
                if (r_rvalid_q && !(ffz != 7'd64 || r_word == 2'd3 || cand >= r_per))
                    r_word <= r_word + 1'b1;
                if (r_rvalid_q) r_idx <= cand;
            end
            // pool exhausted: index reads as zero
            if (r_st == S_ALLOC_END && r_status != ST_OK) r_idx <= '0;
            if (r_st == S_ALLOC_END && r_status == ST_OK) begin
                if (r_idx >= r_per) begin
                    r_status   <= ST_NO_SLAB;
                    r_idx      <= '0;
                    r_cls[r_sel]   <= CL_FULL;
                    r_ctr          <= r_ctr + 1'b1;
                    r_stamp[r_sel] <= r_ctr + 1'b1;
                end else begin : alloc_ok
                    logic [7:0] nu;
                    nu = (r_used[r_sel] < 8'd255) ? r_used[r_sel] + 8'd1 : r_used[r_sel];
                    r_used[r_sel] <= nu;
                    if ({1'b0, nu} >= r_per) begin
                        r_cls[r_sel]   <= CL_FULL;
                        r_ctr          <= r_ctr + 1'b1;
                        r_stamp[r_sel] <= r_ctr + 1'b1;
                    end
                end
            end
            if (r_st == S_DIV) begin
                r_sel <= r_inslab[SW-1:0];
                r_word <= div_q[7:6];
                r_rvalid_q <= 1'b0;
            end
            if (r_st == S_FREE_CHK) begin
                r_rvalid_q <= 1'b1;
                r_word <= div_q[7:6];
            end
            if (r_st == S_FREE_END) begin
                if ((SLAB_COUNT < 16 && 32'(r_inslab) >= SLAB_COUNT) ||
                    r_cls[r_sel] == CL_UNUSED || r_cls[r_sel] == CL_FREE ||
                    r_inoff < OFF_W'(HEADER_BYTES) || fbig || !word_eff[div_q[5:0]]) begin
                    r_status <= ST_BAD;
                    r_idx    <= '0;
                end else begin : free_ok
                    logic wf;
                    logic [7:0] nu;
                    logic [STAMP_W-1:0] c;
                    wf = (r_cls[r_sel] == CL_FULL) || ({1'b0, r_used[r_sel]} >= r_per);
                    nu = (r_used[r_sel] != 8'd0) ? r_used[r_sel] - 8'd1 : 8'd0;
                    c  = r_ctr;
                    r_idx <= {1'b0, fidx};
                    r_used[r_sel] <= nu;
                    if (wf) c = c + 1'b1;
                    if (nu == 8'd0) c = c + 1'b1;
                    // emptied slab ends in free even when it passed through partial
                    if (nu == 8'd0) r_cls[r_sel] <= CL_FREE;
                    else if (wf) r_cls[r_sel] <= CL_PARTIAL;
                    if (wf || nu == 8'd0) r_stamp[r_sel] <= c;
                    r_ctr <= c;
                end
            end
            if (r_st == S_ALLOC_END || r_st == S_FREE_END) begin
                r_prod <= '0;
                r_mcnt <= 4'(IDX_W - 1);
            end
            // shift-add multiply, one index bit per cycle
            if (r_st == S_MUL) begin
                r_prod <= (r_prod << 1) + (r_idx[r_mcnt[2:0]] ? OFF_W'(esz) : OFF_W'(0));
                if (r_mcnt != '0) r_mcnt <= r_mcnt - 1'b1;
            end
        end
    end

    // bitmap word access
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = word_eff;
        mem_addr  = {r_sel, r_word};
        if (r_st == S_ALLOC_END && r_status == ST_OK && r_idx < r_per) begin
            mem_we = 1'b1;
            mem_wdata = word_eff | (64'd1 << r_idx[5:0]);
        end
        if (r_st == S_FREE_END && !((SLAB_COUNT < 16 && 32'(r_inslab) >= SLAB_COUNT) ||
            r_cls[r_sel] == CL_UNUSED || r_cls[r_sel] == CL_FREE ||
            r_inoff < OFF_W'(HEADER_BYTES) || fbig || !word_eff[div_q[5:0]])) begin
            mem_we = 1'b1;
            mem_wdata = word_eff & ~(64'd1 << div_q[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_result_slab   = (r_op == OP_FREE) ? r_inslab
                           : (r_status == ST_NO_SLAB && !r_found && r_idx == '0 &&
                              r_cls[r_sel] != CL_FULL) ? '0 : SLAB_W'(r_sel);
    assign o_object_index  = r_idx[7:0];
    assign o_object_offset = (r_status == ST_OK) ? r_prod + OFF_W'(HEADER_BYTES) : '0;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !busy) |=> busy) else $error("command not taken");
    a_ok_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK) |-> ({1'b0, o_object_index} < r_per))
        else $error("index beyond slab");
endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for slab_bitmap_allocator.
// Holds its own allocator predictor and checks every result word in order.
// Depends on sba_pkg and the design sources.
`timescale 1ns / 1ps
module tb_top;
    import sba_pkg::*;

    localparam int NSLAB    = 16;
    localparam int WD_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLAB_W-1:0] slab;
        logic [IDX_W-1:0]  idx;
        logic [OFF_W-1:0]  off;
    } t_outcome;

    typedef struct packed {
        logic [SLAB_W-1:0] slab;
        logic [OFF_W-1:0]  off;
    } t_live_obj;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              i_start = 1'b0;
    logic              busy;
    logic              i_operation = OP_ALLOC;
    logic [SLAB_W-1:0] i_slab_number = '0;
    logic [OFF_W-1:0]  i_byte_offset = '0;
    logic              o_done;
    logic [1:0]        o_status;
    logic [SLAB_W-1:0] o_result_slab;
    logic [IDX_W-1:0]  o_object_index;
    logic [OFF_W-1:0]  o_object_offset;

    // predictor state
    logic [255:0]  occ_map [NSLAB];
    int unsigned   in_use [NSLAB];
    t_class        slab_cls [NSLAB];
    logic [31:0]   cls_stamp [NSLAB];
    logic [31:0]   stamp_now;
    logic [SIZE_W-1:0] obj_size_reg;

    t_outcome  awaited_results [$];
    t_live_obj live_objects [$];
    int        mismatches = 0;
    int        idle_cycles = 0;

    slab_bitmap_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_slab_number  (i_slab_number),
        .i_byte_offset  (i_byte_offset),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_slab  (o_result_slab),
        .o_object_index (o_object_index),
        .o_object_offset(o_object_offset)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned obj_bytes();
        return (obj_size_reg < 16) ? 16 : int'(obj_size_reg);
    endfunction

    function automatic int unsigned slots_per_slab();
        int unsigned sz, pages, per;
        sz = obj_bytes();
        pages = (sz < 64) ? 1 : 1 + (sz * 8 - 1) / PAGE_BYTES;
        per = (pages * PAGE_BYTES - HEADER_BYTES) / sz;
        return (per > 256) ? 256 : per;
    endfunction

    function automatic void relist(int s, t_class c);
        stamp_now = stamp_now + 1;
        slab_cls[s] = c;
        cls_stamp[s] = stamp_now;
    endfunction

    // newest slab of a class, lowest number on a stamp tie
    function automatic int newest_slab(t_class c);
        int best;
        best = -1;
        for (int s = 0; s < NSLAB; s++)
            if (slab_cls[s] == c && (best < 0 || cls_stamp[s] > cls_stamp[best]))
                best = s;
        return best;
    endfunction

    function automatic void reset_allocator();
        for (int s = 0; s < NSLAB; s++) begin
            occ_map[s] = '0;
            in_use[s] = 0;
            slab_cls[s] = CL_UNUSED;
            cls_stamp[s] = '0;
        end
        stamp_now = '0;
        obj_size_reg = SIZE_W'(16);
    endfunction

    function automatic t_outcome predict_alloc();
        t_outcome r;
        int sel, i;
        int unsigned per;
        per = slots_per_slab();
        r = '0;
        sel = newest_slab(CL_PARTIAL);
        if (sel < 0) begin
            sel = newest_slab(CL_FREE);
            if (sel < 0) begin
                for (int s = NSLAB - 1; s >= 0; s--)
                    if (slab_cls[s] == CL_UNUSED) sel = s;
                if (sel < 0) begin
                    r.status = ST_NO_SLAB;
                    return r;
                end
                occ_map[sel] = '0;
                in_use[sel] = 0;
                relist(sel, CL_FREE);
            end
            relist(sel, CL_PARTIAL);
        end
        r.slab = SLAB_W'(sel);
        for (i = 0; i < per; i++)
            if (!occ_map[sel][i]) break;
        if (i >= per) begin
            // slot count shrank under a live slab
            relist(sel, CL_FULL);
            r.status = ST_NO_SLAB;
            return r;
        end
        occ_map[sel][i] = 1'b1;
        if (in_use[sel] < 255) in_use[sel]++;
        if (in_use[sel] >= per) relist(sel, CL_FULL);
        r.status = ST_OK;
        r.idx = IDX_W'(i);
        r.off = OFF_W'(HEADER_BYTES + i * obj_bytes());
        return r;
    endfunction

    function automatic t_outcome predict_free(logic [SLAB_W-1:0] sn, logic [OFF_W-1:0] bo);
        t_outcome r;
        int unsigned per, i;
        int s;
        per = slots_per_slab();
        s = int'(sn);
        r = '0;
        r.status = ST_BAD;
        r.slab = sn;
        if (slab_cls[s] == CL_UNUSED || slab_cls[s] == CL_FREE) return r;
        if (bo < HEADER_BYTES) return r;
        i = (int'(bo) - HEADER_BYTES) / obj_bytes();
        if (i >= per || !occ_map[s][i]) return r;
        occ_map[s][i] = 1'b0;
        if (slab_cls[s] == CL_FULL || in_use[s] >= per) relist(s, CL_PARTIAL);
        if (in_use[s] > 0) in_use[s]--;
        if (in_use[s] == 0) relist(s, CL_FREE);
        r.status = ST_OK;
        r.idx = IDX_W'(i);
        r.off = OFF_W'(HEADER_BYTES + i * obj_bytes());
        return r;
    endfunction

    // one command word; start stays high on return
    task automatic issue_word(logic op, logic [SLAB_W-1:0] sn, logic [OFF_W-1:0] bo,
                              int idle_pct);
        int gap;
        t_outcome r;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 200) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        i_start <= 1'b1;
        i_operation <= op;
        i_slab_number <= sn;
        i_byte_offset <= bo;
        do @(posedge i_clk); while (busy);
        if (op == OP_ALLOC) begin
            r = predict_alloc();
            if (r.status == ST_OK) live_objects.push_back({r.slab, r.off});
        end else begin
            r = predict_free(sn, bo);
        end
        awaited_results.push_back(r);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_object_size(logic [SIZE_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        obj_size_reg = v;
    endtask

    task automatic test_directed();
        set_object_size(SIZE_W'(16));
        repeat (3) issue_word(OP_ALLOC, 4'hF, 15'h7FFF, 0);
        issue_word(OP_FREE, 4'd0, OFF_W'(32 + 16 + 5), 0);     // misaligned slot 1
        issue_word(OP_FREE, 4'd0, OFF_W'(48), 0);              // double free
        issue_word(OP_FREE, 4'd0, OFF_W'(0), 0);               // inside header
        issue_word(OP_FREE, 4'd0, 15'h7FFF, 0);                // past last slot
        issue_word(OP_FREE, 4'hF, OFF_W'(32), 0);              // unused slab
        issue_word(OP_ALLOC, 4'd0, '0, 0);
        issue_word(OP_FREE, 4'd0, OFF_W'(32), 0);
        issue_word(OP_FREE, 4'd0, OFF_W'(48), 0);
        issue_word(OP_FREE, 4'd0, OFF_W'(64), 0);              // slab back to free
        issue_word(OP_FREE, 4'd0, OFF_W'(64), 0);              // free slab
        issue_word(OP_ALLOC, 4'h5, 15'h1234, 0);
        live_objects.delete();
    endtask

    // size drops the slot count under a partial slab
    task automatic test_shrunk_slab();
        set_object_size(SIZE_W'(0));
        repeat (10) issue_word(OP_ALLOC, '0, '0, 0);
        set_object_size(SIZE_W'(4095));
        issue_word(OP_ALLOC, '0, '0, 0);
        issue_word(OP_ALLOC, '0, '0, 0);
        live_objects.delete();
    endtask

    task automatic test_random(logic [SIZE_W-1:0] sz, int n, int alloc_pct, int idle_pct);
        int k;
        t_live_obj o;
        set_object_size(sz);
        repeat (n) begin
            if ($urandom_range(99) < alloc_pct) begin
                issue_word(OP_ALLOC, SLAB_W'($urandom), OFF_W'($urandom), idle_pct);
            end else if (live_objects.size() != 0 && $urandom_range(99) < 85) begin
                k = $urandom_range(live_objects.size() - 1);
                o = live_objects[k];
                live_objects.delete(k);
                if ($urandom_range(3) == 0) o.off = o.off + OFF_W'($urandom_range(15));
                issue_word(OP_FREE, o.slab, o.off, idle_pct);
            end else begin
                issue_word(OP_FREE, SLAB_W'($urandom), OFF_W'($urandom), idle_pct);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d slab %0d idx %0d off %0d",
                             o_status, o_result_slab, o_object_index, o_object_offset);
            end else begin
                want = awaited_results.pop_front();
                if (want.status !== o_status || want.slab !== o_result_slab ||
                    want.idx !== o_object_index || want.off !== o_object_offset) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.status, want.slab, want.idx, want.off, o_status,
                                 o_result_slab, o_object_index, o_object_offset);
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        reset_allocator();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_shrunk_slab();
        test_random(SIZE_W'(15), 120, 60, 0);
        test_random(SIZE_W'(16), 300, 92, 0);
        test_random(SIZE_W'(4095), 200, 80, 88);
        test_random(SIZE_W'(64), 150, 55, 21);
        test_random(SIZE_W'(63), 150, 50, 0);
        test_random(SIZE_W'(1000), 120, 50, 88);
        test_random(SIZE_W'(2048), 120, 60, 21);
        test_random(SIZE_W'(4095), 120, 35, 0);
        drain();
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
